// ===== rtl/tfp_pkg.sv =====
package tfp_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int CENTER_W       = 10;
  localparam int GAIN_W         = 16;
  localparam int STEP_W         = 16;
  localparam int LIMIT_W        = 15;
  localparam int TURN_W         = 16;
  localparam int INTEG_W        = 32;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int MUL_A_W        = INTEG_W + 1;
  localparam int MUL_B_W        = STEP_W + 1;
  localparam int PROD_W         = MUL_A_W + MUL_B_W;

  localparam logic signed [MUL_B_W-1:0] BACKOFF_Q16 = MUL_B_W'(64881);

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_CENTER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D_PER_DT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT   = 3'd5;

  localparam logic [CENTER_W-1:0]      RST_TARGET_CENTER = CENTER_W'(160);
  localparam logic signed [GAIN_W-1:0] RST_GAIN_P        = GAIN_W'(256);
  localparam logic signed [GAIN_W-1:0] RST_GAIN_I        = GAIN_W'(0);
  localparam logic signed [GAIN_W-1:0] RST_GAIN_D        = GAIN_W'(0);
  localparam logic [STEP_W-1:0]        RST_STEP_TIME     = STEP_W'(256);
  localparam logic [LIMIT_W-1:0]       RST_DRIVE_LIMIT   = LIMIT_W'(32767);

  typedef struct packed {
    logic [CENTER_W-1:0]      target_center;
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d_per_dt;
    logic [STEP_W-1:0]        step_time;
    logic [LIMIT_W-1:0]       drive_limit;
  } tfp_cfg_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_MUL_ST,
    OP_MUL_P,
    OP_MUL_D,
    OP_MUL_I,
    OP_SUM,
    OP_CLAMP,
    OP_BACKOFF
  } tfp_op_e;

  typedef struct packed {
    logic    load;
    tfp_op_e op;
  } tfp_cmd_t;

  typedef struct packed {
    logic clip;
  } tfp_status_t;

endpackage

// ===== rtl/tfp_in_if.sv =====
interface tfp_in_if #(
  parameter int COORD_BITS = tfp_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] object_x;

  modport source (output valid, output object_x, input ready);
  modport sink (input valid, input object_x, output ready);
endinterface

// ===== rtl/tfp_out_if.sv =====
interface tfp_out_if;
  import tfp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [TURN_W-1:0] turn_drive;
  logic                     clamped;

  modport source (output valid, output turn_drive, output clamped, input ready);
  modport sink (input valid, input turn_drive, input clamped, output ready);
endinterface

// ===== rtl/tfp_cfg_if.sv =====
interface tfp_cfg_if;
  import tfp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/tfp_cfg_regs.sv =====
module tfp_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic [tfp_pkg::CFG_IDX_W-1:0]   index_i,
  input  logic [tfp_pkg::CFG_DATA_W-1:0]  data_i,
  output tfp_pkg::tfp_cfg_t               cfg_o
);
  import tfp_pkg::*;

  tfp_cfg_t cfg_q;

  assign ready_o = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_center <= RST_TARGET_CENTER;
      cfg_q.gain_p        <= RST_GAIN_P;
      cfg_q.gain_i        <= RST_GAIN_I;
      cfg_q.gain_d_per_dt <= RST_GAIN_D;
      cfg_q.step_time     <= RST_STEP_TIME;
      cfg_q.drive_limit   <= RST_DRIVE_LIMIT;
    end else if (valid_i) begin
      case (index_i)
        REG_TARGET_CENTER: cfg_q.target_center <= data_i[CENTER_W-1:0];
        REG_GAIN_P:        cfg_q.gain_p        <= $signed(data_i[GAIN_W-1:0]);
        REG_GAIN_I:        cfg_q.gain_i        <= $signed(data_i[GAIN_W-1:0]);
        REG_GAIN_D_PER_DT: cfg_q.gain_d_per_dt <= $signed(data_i[GAIN_W-1:0]);
        REG_STEP_TIME:     cfg_q.step_time     <= data_i[STEP_W-1:0];
        REG_DRIVE_LIMIT:   cfg_q.drive_limit   <= data_i[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/tfp_datapath.sv =====
module tfp_datapath #(
  parameter int COORD_BITS = tfp_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tfp_pkg::tfp_cmd_t                 cmd_i,
  output tfp_pkg::tfp_status_t              status_o,
  input  tfp_pkg::tfp_cfg_t                 cfg_i,
  input  logic [COORD_BITS-1:0]             object_x_i,
  output logic signed [tfp_pkg::TURN_W-1:0] turn_drive_o,
  output logic                              clamped_o
);
  import tfp_pkg::*;

  localparam int ERR_W  = ((COORD_BITS > CENTER_W) ? COORD_BITS : CENTER_W) + 1;
  localparam int DIFF_W = ERR_W + 1;
  localparam int DRV_W  = ERR_W + 19;
  localparam int SUM_W  = PROD_W + 9;

  logic [ERR_W-1:0]         center_ext;
  logic [ERR_W-1:0]         x_ext;
  logic signed [ERR_W-1:0]  err_d;
  logic signed [DIFF_W-1:0] diff_d;

  logic signed [ERR_W-1:0]   err_q;
  logic signed [DIFF_W-1:0]  diff_q;
  logic signed [ERR_W-1:0]   prev_err_q;
  logic signed [INTEG_W-1:0] integral_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [DRV_W-1:0]   drive_q;
  logic signed [TURN_W-1:0]  turn_q;
  logic                      clamped_q;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  logic signed [SUM_W-1:0]   int_sum;
  logic [SUM_W-INTEG_W:0]    int_top;
  logic signed [INTEG_W-1:0] int_sat;

  logic signed [DRV_W-1:0]   lim;
  logic signed [DRV_W-1:0]   neg_lim;
  logic                      over;
  logic                      under;
  logic signed [DRV_W-1:0]   drv_clamped;
  logic signed [DRV_W-1:0]   drv_neg;

  assign center_ext = ERR_W'(cfg_i.target_center);
  assign x_ext      = ERR_W'(object_x_i);
  assign err_d      = $signed(center_ext - x_ext);
  assign diff_d     = DIFF_W'(err_d) - DIFF_W'(prev_err_q);

  always_comb begin
    case (cmd_i.op)
      OP_MUL_ST: begin
        mul_a = MUL_A_W'(err_q);
        mul_b = $signed({1'b0, cfg_i.step_time});
      end
      OP_MUL_P: begin
        mul_a = MUL_A_W'(err_q);
        mul_b = MUL_B_W'(cfg_i.gain_p);
      end
      OP_MUL_D: begin
        mul_a = MUL_A_W'(diff_q);
        mul_b = MUL_B_W'(cfg_i.gain_d_per_dt);
      end
      OP_MUL_I: begin
        mul_a = MUL_A_W'(integral_q);
        mul_b = MUL_B_W'(cfg_i.gain_i);
      end
      default: begin
        mul_a = MUL_A_W'(integral_q);
        mul_b = BACKOFF_Q16;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // saturating integral add of the error times step time, q8.8 to q16.16
  assign int_sum = SUM_W'(integral_q) + (SUM_W'(prod_q) <<< 8);
  assign int_top = int_sum[SUM_W-1:INTEG_W-1];
  always_comb begin
    if ((&int_top) || !(|int_top)) begin
      int_sat = int_sum[INTEG_W-1:0];
    end else if (int_sum[SUM_W-1]) begin
      int_sat = {1'b1, {(INTEG_W-1){1'b0}}};
    end else begin
      int_sat = {1'b0, {(INTEG_W-1){1'b1}}};
    end
  end

  assign lim     = $signed(DRV_W'(cfg_i.drive_limit));
  assign neg_lim = -lim;
  assign over    = drive_q > lim;
  assign under   = drive_q < neg_lim;

  always_comb begin
    if (over) begin
      drv_clamped = lim;
    end else if (under) begin
      drv_clamped = neg_lim;
    end else begin
      drv_clamped = drive_q;
    end
  end

  assign drv_neg       = -drv_clamped;
  assign status_o.clip = over || under;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
      integral_q <= '0;
    end else begin
      if (cmd_i.load) begin
        prev_err_q <= err_d;
      end
      case (cmd_i.op)
        OP_MUL_P:   integral_q <= int_sat;
        OP_BACKOFF: integral_q <= INTEG_W'(prod_q >>> 16);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      err_q  <= err_d;
      diff_q <= diff_d;
    end
    if (cmd_i.op != OP_NONE) begin
      prod_q <= mul_p;
    end
    case (cmd_i.op)
      OP_MUL_D: drive_q <= DRV_W'(prod_q);
      OP_MUL_I: drive_q <= drive_q + DRV_W'(prod_q);
      OP_SUM:   drive_q <= drive_q + DRV_W'(prod_q >>> 24);
      OP_CLAMP: begin
        turn_q    <= TURN_W'(drv_neg);
        clamped_q <= over || under;
      end
      default: begin
      end
    endcase
  end

  assign turn_drive_o = turn_q;
  assign clamped_o    = clamped_q;

endmodule

// ===== rtl/tfp_ctrl.sv =====
module tfp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tfp_pkg::tfp_cmd_t    cmd_o,
  input  tfp_pkg::tfp_status_t status_i
);
  import tfp_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_MUL_ST  = 3'd1;
  localparam logic [2:0] S_MUL_P   = 3'd2;
  localparam logic [2:0] S_MUL_D   = 3'd3;
  localparam logic [2:0] S_MUL_I   = 3'd4;
  localparam logic [2:0] S_SUM     = 3'd5;
  localparam logic [2:0] S_CLAMP   = 3'd6;
  localparam logic [2:0] S_BACKOFF = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.load  = 1'b0;
    cmd_o.op    = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL_ST;
        end
      end
      S_MUL_ST: begin
        cmd_o.op = OP_MUL_ST;
        state_d  = S_MUL_P;
      end
      S_MUL_P: begin
        cmd_o.op = OP_MUL_P;
        state_d  = S_MUL_D;
      end
      S_MUL_D: begin
        cmd_o.op = OP_MUL_D;
        state_d  = S_MUL_I;
      end
      S_MUL_I: begin
        cmd_o.op = OP_MUL_I;
        state_d  = S_SUM;
      end
      S_SUM: begin
        cmd_o.op = OP_SUM;
        state_d  = S_CLAMP;
      end
      S_CLAMP: begin
        if (out_free) begin
          cmd_o.op    = OP_CLAMP;
          out_valid_d = 1'b1;
          state_d     = status_i.clip ? S_BACKOFF : S_IDLE;
        end
      end
      S_BACKOFF: begin
        cmd_o.op = OP_BACKOFF;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_MUL_ST)
    else $error("accepted request did not start the multiply sequence");

  a_result_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == OP_CLAMP |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while pending");

  a_clip_backoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == OP_CLAMP && status_i.clip |=> state_q == S_BACKOFF)
    else $error("clamp without integral back-off");

  a_backoff_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_BACKOFF |=> state_q == S_IDLE && out_valid_q || state_q == S_IDLE)
    else $error("back-off did not return to idle");

endmodule

// ===== rtl/trail_follow_pid_unit.sv =====
// Trail-following PID turn controller. Each request carries one measured x coordinate; the
// block forms error = target_center - object_x, updates a saturating Q16.16 integral, sums
// the P, D and I terms, clamps to +/- drive_limit (scaling the integral by 0.99 on a clamp)
// and returns the negated drive with a clamp flag. All products go through one shared
// 33x17 multiplier, one product per cycle; an item runs through an accept step, five
// multiply/add steps and the clamp step before the next request is taken, and through the
// integral back-off step as well when the drive clamps. The result sits in an output
// register; if it has not been taken when the next result is due, the clamp step waits.
// Configuration writes are taken every cycle and should only be issued while idle.
module trail_follow_pid_unit #(
  parameter int COORD_BITS = tfp_pkg::COORD_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tfp_in_if.sink     in_i,
  tfp_out_if.source  out_o,
  tfp_cfg_if.sink    cfg_i
);
  import tfp_pkg::*;

  tfp_cfg_t    cfg;
  tfp_cmd_t    cmd;
  tfp_status_t status;

  tfp_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cfg_i.valid),
    .ready_o (cfg_i.ready),
    .index_i (cfg_i.index),
    .data_i  (cfg_i.data),
    .cfg_o   (cfg)
  );

  tfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  tfp_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_i        (cfg),
    .object_x_i   (in_i.object_x),
    .turn_drive_o (out_o.turn_drive),
    .clamped_o    (out_o.clamped)
  );

endmodule

// ===== tb/sv/trail_follow_pid_unit_test.sv =====
`timescale 1ns / 1ps

module trail_follow_pid_unit_test;
  import tfp_pkg::*;

  localparam int COORD_W     = COORD_BITS_DEF;
  localparam int SETTLE      = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;
  localparam int BLOCKS      = 8;
  localparam int BLOCK_ITEMS = 54;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic signed [TURN_W-1:0] turn;
    logic                     clamped;
  } drive_result_t;

  typedef enum logic {
    ROW_WRITE,
    ROW_COORD
  } row_kind_e;

  typedef struct packed {
    row_kind_e                kind;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_DATA_W-1:0]    value;
    logic                     typed;
    logic signed [TURN_W-1:0] turn;
    logic                     clamped;
  } script_row_t;

  localparam int SCRIPT_LEN = 39;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{ROW_COORD, '0, 16'd160, 1'b1, 16'sd0, 1'b0},
    '{ROW_COORD, '0, 16'd0, 1'b1, -16'sd32767, 1'b1},
    '{ROW_COORD, '0, 16'd1023, 1'b1, 16'sd32767, 1'b1},
    // zero drive limit
    '{ROW_WRITE, REG_DRIVE_LIMIT, 16'd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_COORD, '0, 16'd160, 1'b1, 16'sd0, 1'b0},
    '{ROW_COORD, '0, 16'd100, 1'b1, 16'sd0, 1'b1},
    // drive landing exactly on the limit, then just past it
    '{ROW_WRITE, REG_DRIVE_LIMIT, 16'd2560, 1'b0, 16'sd0, 1'b0},
    '{ROW_COORD, '0, 16'd150, 1'b1, -16'sd2560, 1'b0},
    '{ROW_COORD, '0, 16'd149, 1'b1, -16'sd2560, 1'b1},
    '{ROW_COORD, '0, 16'd171, 1'b1, 16'sd2560, 1'b1},
    // writes past the register list change nothing
    '{ROW_WRITE, REG_SPARE_6, 16'hFFFF, 1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE, REG_SPARE_7, 16'h5A5A, 1'b0, 16'sd0, 1'b0},
    '{ROW_COORD, '0, 16'd150, 1'b1, -16'sd2560, 1'b0},
    // extreme gains, positive integral saturation
    '{ROW_WRITE, REG_GAIN_I, 16'h7FFF, 1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE, REG_STEP_TIME, 16'hFFFF, 1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE, REG_TARGET_CENTER, 16'hFFFF, 1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE, REG_DRIVE_LIMIT, 16'hFFFF, 1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE, REG_GAIN_D_PER_DT, 16'h8000, 1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE, REG_GAIN_P, 16'h7FFF, 1'b0, 16'sd0, 1'b0},
    '{ROW_COORD, '0, 16'd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_COORD, '0, 16'd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_COORD, '0, 16'd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_COORD, '0, 16'd1023, 1'b0, 16'sd0, 1'b0},
    '{ROW_COORD, '0, 16'd1023, 1'b0, 16'sd0, 1'b0},
    '{ROW_COORD, '0, 16'd1023, 1'b0, 16'sd0, 1'b0},
    '{ROW_COORD, '0, 16'd512, 1'b0, 16'sd0, 1'b0},
    // opposite extremes
    '{ROW_WRITE, REG_GAIN_P, 16'h8000, 1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE, REG_GAIN_I, 16'h8000, 1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE, REG_GAIN_D_PER_DT, 16'h7FFF, 1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE, REG_TARGET_CENTER, 16'd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE, REG_STEP_TIME, 16'd1, 1'b0, 16'sd0, 1'b0},
    '{ROW_COORD, '0, 16'd1023, 1'b0, 16'sd0, 1'b0},
    '{ROW_COORD, '0, 16'd1023, 1'b0, 16'sd0, 1'b0},
    '{ROW_COORD, '0, 16'd1023, 1'b0, 16'sd0, 1'b0},
    '{ROW_COORD, '0, 16'd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_COORD, '0, 16'h2AA, 1'b0, 16'sd0, 1'b0},
    '{ROW_COORD, '0, 16'h155, 1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE, REG_STEP_TIME, 16'd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_COORD, '0, 16'd1, 1'b0, 16'sd0, 1'b0}
  };

  logic clk_i;
  logic rst_ni;

  tfp_in_if #(.COORD_BITS(COORD_W)) in_if ();
  tfp_out_if out_if ();
  tfp_cfg_if cfg_if ();

  trail_follow_pid_unit #(.COORD_BITS(COORD_W)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // controller copy: settings and loop state
  logic [CENTER_W-1:0]      center_px  = RST_TARGET_CENTER;
  logic signed [GAIN_W-1:0] kp         = RST_GAIN_P;
  logic signed [GAIN_W-1:0] ki         = RST_GAIN_I;
  logic signed [GAIN_W-1:0] kd         = RST_GAIN_D;
  logic [STEP_W-1:0]        dt         = RST_STEP_TIME;
  logic [LIMIT_W-1:0]       turn_limit = RST_DRIVE_LIMIT;
  int                       last_err   = 0;
  int                       integ_q16  = 0;

  drive_result_t turns_due[$];
  int            mismatches = 0;
  int            cycles     = 0;
  int            src_idle_pct   = 0;
  int            sink_stall_pct = 0;

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] v);
    case (idx)
      REG_TARGET_CENTER: center_px = v[CENTER_W-1:0];
      REG_GAIN_P:        kp = v;
      REG_GAIN_I:        ki = v;
      REG_GAIN_D_PER_DT: kd = v;
      REG_STEP_TIME:     dt = v;
      REG_DRIVE_LIMIT:   turn_limit = v[LIMIT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic drive_result_t compute_turn(input logic [COORD_W-1:0] x);
    longint        err;
    longint        acc;
    longint        drive;
    longint        lim;
    drive_result_t r;
    err = longint'(center_px) - longint'(x);
    acc = longint'(integ_q16) + err * longint'(dt) * 256;
    if (acc > 64'sd2147483647) begin
      acc = 64'sd2147483647;
    end else if (acc < -64'sd2147483648) begin
      acc = -64'sd2147483648;
    end
    integ_q16 = int'(acc);
    drive = err * longint'(kp) + (err - longint'(last_err)) * longint'(kd)
          + ((longint'(integ_q16) * longint'(ki)) >>> 24);
    last_err = int'(err);
    lim = longint'(turn_limit);
    r.clamped = 1'b0;
    if (drive > lim) begin
      drive = lim;
      r.clamped = 1'b1;
    end else if (drive < -lim) begin
      drive = -lim;
      r.clamped = 1'b1;
    end
    if (r.clamped) begin
      integ_q16 = int'((longint'(integ_q16) * longint'(BACKOFF_Q16)) >>> 16);
    end
    r.turn = TURN_W'(-drive);
    return r;
  endfunction

  // leaves valid high; the caller lowers it or sends the next request
  task automatic send_coord(input logic [COORD_W-1:0] x, input logic typed,
                            input drive_result_t given);
    drive_result_t r;
    while (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.object_x <= x;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    r = compute_turn(x);
    turns_due.push_back(typed ? given : r);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= v;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    apply_reg(idx, v);
    @(negedge clk_i);
  endtask

  // stop requests and wait out every pending result plus the back-off step
  task automatic drain();
    in_if.valid <= 1'b0;
    while (turns_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** trail_follow_pid_unit: FAILED **");
      $finish;
    end
  end

  always @(posedge clk_i) begin : check_turns
    drive_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (turns_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected result: turn_drive %0d clamped %0b",
                   out_if.turn_drive, out_if.clamped);
        end
      end else begin
        want = turns_due.pop_front();
        if (out_if.turn_drive !== want.turn || out_if.clamped !== want.clamped) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: turn_drive exp %0d got %0d, clamped exp %0b got %0b",
                     want.turn, out_if.turn_drive, want.clamped, out_if.clamped);
          end
        end
      end
    end
  end

  initial begin
    drive_result_t          given;
    logic                   writing;
    logic [COORD_W-1:0]     x;
    logic [CFG_DATA_W-1:0]  v;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.object_x  = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    writing         = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed walk, no idling
    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].kind == ROW_WRITE) begin
        if (!writing) begin
          drain();
          writing = 1'b1;
        end
        write_reg(SCRIPT[i].idx, SCRIPT[i].value);
      end else begin
        if (writing) begin
          cfg_if.valid <= 1'b0;
          writing = 1'b0;
        end
        given.turn    = SCRIPT[i].turn;
        given.clamped = SCRIPT[i].clamped;
        send_coord(SCRIPT[i].value[COORD_W-1:0], SCRIPT[i].typed, given);
      end
    end

    // random blocks, fresh settings and idling pattern for each
    given = '0;
    for (int blk = 0; blk < BLOCKS; blk++) begin
      drain();
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      write_reg(REG_TARGET_CENTER, 16'($urandom));
      v = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2047) - 1024);
      write_reg(REG_GAIN_P, v);
      v = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 255) - 128);
      write_reg(REG_GAIN_I, v);
      v = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023) - 512);
      write_reg(REG_GAIN_D_PER_DT, v);
      v = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
      write_reg(REG_STEP_TIME, v);
      write_reg(REG_DRIVE_LIMIT, 16'($urandom));
      if ($urandom_range(0, 2) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, 16'($urandom));
      end
      cfg_if.valid <= 1'b0;
      case (blk % 4)
        1: src_idle_pct = 75;
        2: sink_stall_pct = 75;
        3: begin
          src_idle_pct   = 11;
          sink_stall_pct = 11;
        end
        default: ;
      endcase
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        if (n == BLOCK_ITEMS / 2 && blk % 2 == 1) begin
          drain();
        end
        if ($urandom_range(0, 3) == 0) begin
          x = COORD_W'($urandom);
        end else begin
          x = COORD_W'(center_px + $urandom_range(0, 80) - 40);
        end
        send_coord(x, 1'b0, given);
      end
    end

    drain();
    if (mismatches == 0 && turns_due.size() == 0) begin
      $display("** trail_follow_pid_unit: PASSED **");
    end else begin
      $display("** trail_follow_pid_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tfp_pkg.sv
rtl/tfp_in_if.sv
rtl/tfp_out_if.sv
rtl/tfp_cfg_if.sv
rtl/tfp_cfg_regs.sv
rtl/tfp_datapath.sv
rtl/tfp_ctrl.sv
rtl/trail_follow_pid_unit.sv
tb/sv/trail_follow_pid_unit_test.sv
